// ===== rtl/core/cdp_pkg.sv =====
package cdp_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int WD_W    = 3;
	localparam int YDAY_W  = 9;
	localparam int Q100_W  = 8;
	localparam int Q400_W  = 6;
	localparam int WSUM_W  = 15;

	localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

	localparam int DIV100_MUL_W = 13;
	localparam int DIV100_PROD_W = YEAR_W + DIV100_MUL_W;
	localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
	localparam int DIV100_SHIFT = 19;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	localparam logic [WD_W-1:0] WD_FRIDAY   = 3'd5;
	localparam logic [WD_W-1:0] WD_SATURDAY = 3'd6;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [YEAR_W-1:0]  wk_year;
		logic [Q100_W-1:0]  year_q100;
		logic [Q100_W-1:0]  wk_q100;
		logic [Q400_W-1:0]  wk_q400;
	} cdp_s2_t;

	typedef struct packed {
		logic               date_valid;
		logic [WD_W-1:0]    weekday;
		logic               end_of_week;
		logic               weekend;
		logic               leap_year;
		logic [DAY_W-1:0]   month_length;
		logic [WD_W-1:0]    left_in_week;
		logic [DAY_W-1:0]   left_in_month;
		logic [YDAY_W-1:0]  left_in_year;
		logic [DAY_W-1:0]   next_day;
		logic [MONTH_W-1:0] next_month;
		logic [YEAR_W-1:0]  next_year;
	} cdp_res_t;

	function automatic logic [DAY_W-1:0] month_days_f(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] r;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
			4'd2:                                       r = 5'd28;
			default:                                    r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic [YDAY_W-1:0] days_before_f(input logic [MONTH_W-1:0] m);
		logic [YDAY_W-1:0] r;
		unique case (m)
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// floor(31 * m / 12) for the March-based month number
	function automatic logic [DAY_W-1:0] month_term_f(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] r;
		unique case (m)
			4'd1:    r = 5'd2;
			4'd2:    r = 5'd5;
			4'd3:    r = 5'd7;
			4'd4:    r = 5'd10;
			4'd5:    r = 5'd12;
			4'd6:    r = 5'd15;
			4'd7:    r = 5'd18;
			4'd8:    r = 5'd20;
			4'd9:    r = 5'd23;
			4'd10:   r = 5'd25;
			4'd11:   r = 5'd28;
			4'd12:   r = 5'd31;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// 8 is 1 mod 7: fold octal digits
	function automatic logic [WD_W-1:0] mod7_f(input logic [WSUM_W-1:0] s);
		logic [5:0] f;
		logic [3:0] g;
		logic [3:0] h;
		f = 6'(s[2:0]) + 6'(s[5:3]) + 6'(s[8:6]) + 6'(s[11:9]) + 6'(s[14:12]);
		g = 4'(f[2:0]) + 4'(f[5:3]);
		h = (g >= 4'd7) ? g - 4'd7 : g;
		return (h == 4'd7) ? 3'd0 : h[2:0];
	endfunction

endpackage

// ===== rtl/core/cdp_calc.sv =====
module cdp_calc import cdp_pkg::*; (
	input  cdp_s2_t  s2,
	output cdp_res_t res
);

	logic               leap;
	logic               ok;
	logic [DAY_W-1:0]   mlen;
	logic [MONTH_W-1:0] mm;
	logic [WSUM_W-1:0]  wsum;
	logic [WD_W-1:0]    wd;
	logic [YDAY_W-1:0]  doy;
	logic [YDAY_W-1:0]  ylen;
	logic [YEAR_W-1:0]  cent;

	always_comb begin
		cent = YEAR_W'(s2.year_q100) * 14'd100;
		leap = (s2.year[1:0] == 2'b00) && ((s2.year != cent) || (s2.year_q100[1:0] == 2'b00));
		mlen = (s2.month == MONTH_FEB) ? (leap ? 5'd29 : 5'd28) : month_days_f(s2.month);
		ok = (s2.year != '0) && (s2.year <= YEAR_MAX)
			&& (s2.month >= MONTH_JAN) && (s2.month <= MONTH_DEC)
			&& (s2.day != '0) && (s2.day <= mlen);

		mm = (s2.month <= MONTH_FEB) ? s2.month + 4'd10 : s2.month - 4'd2;
		wsum = WSUM_W'(s2.day) + WSUM_W'(s2.wk_year) + WSUM_W'(s2.wk_year[YEAR_W-1:2])
			- WSUM_W'(s2.wk_q100) + WSUM_W'(s2.wk_q400) + WSUM_W'(month_term_f(mm));
		wd = mod7_f(wsum);

		doy = days_before_f(s2.month) + YDAY_W'(s2.day)
			+ YDAY_W'(leap && (s2.month > MONTH_FEB));
		ylen = leap ? 9'd366 : 9'd365;

		res = '0;
		if (ok) begin
			res.date_valid    = 1'b1;
			res.weekday       = wd;
			res.end_of_week   = (wd == WD_SATURDAY);
			res.weekend       = (wd == WD_FRIDAY) || (wd == WD_SATURDAY);
			res.leap_year     = leap;
			res.month_length  = mlen;
			res.left_in_week  = WD_SATURDAY - wd;
			res.left_in_month = mlen - s2.day;
			res.left_in_year  = ylen - doy + 9'd1;
			if (s2.day == mlen) begin
				res.next_day = 5'd1;
				if (s2.month == MONTH_DEC) begin
					res.next_month = MONTH_JAN;
					res.next_year  = s2.year + 14'd1;
				end else begin
					res.next_month = s2.month + 4'd1;
					res.next_year  = s2.year;
				end
			end else begin
				res.next_day   = s2.day + 5'd1;
				res.next_month = s2.month;
				res.next_year  = s2.year;
			end
		end
	end

endmodule

// ===== rtl/core/calendar_date_properties.sv =====
// Gregorian date properties. One date (year, month, day) goes in per transfer and one result
// comes out: day of week (0 Sunday), Saturday and Friday-or-Saturday flags, leap year, month
// length, days left in the week, month and year (December 31 counts as one), and the following
// date. Month 0 or above 12, day 0 or past the month end, or a year of 0 or above 9999 gives
// date_valid low with every other result field zero. The block takes one date per cycle unless
// in_stall is high; each result passes an input register, a register
// after the constant-reciprocal divisions of the year by 100 and 400, and the result register.
// A stalled output does not block input until all three stages hold a date.
module calendar_date_properties import cdp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [YEAR_W-1:0]  year,
	input  logic [MONTH_W-1:0] month,
	input  logic [DAY_W-1:0]   day,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               date_valid,
	output logic [WD_W-1:0]    weekday,
	output logic               end_of_week,
	output logic               weekend,
	output logic               leap_year,
	output logic [DAY_W-1:0]   month_length,
	output logic [WD_W-1:0]    left_in_week,
	output logic [DAY_W-1:0]   left_in_month,
	output logic [YDAY_W-1:0]  left_in_year,
	output logic [DAY_W-1:0]   next_day,
	output logic [MONTH_W-1:0] next_month,
	output logic [YEAR_W-1:0]  next_year
);

	logic               vld_s1;
	logic [YEAR_W-1:0]  year_s1;
	logic [MONTH_W-1:0] month_s1;
	logic [DAY_W-1:0]   day_s1;
	logic               vld_s2;
	cdp_s2_t            data_s2;
	cdp_s2_t            data_nxt;
	logic               res_vld_q;
	cdp_res_t           res_q;
	cdp_res_t           res_nxt;
	logic               rdy_out;
	logic               rdy_s2;
	logic               rdy_s1;

	logic [YEAR_W-1:0]        wk_year;
	logic [DIV100_PROD_W-1:0] prod_y;
	logic [DIV100_PROD_W-1:0] prod_w;
	logic [DIV100_PROD_W-1:0] prod_w4;

	assign rdy_out  = !res_vld_q || !out_stall;
	assign rdy_s2   = !vld_s2 || rdy_out;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			year_s1  <= year;
			month_s1 <= month;
			day_s1   <= day;
		end
	end

	always_comb begin
		wk_year = (month_s1 <= MONTH_FEB) ? year_s1 - 14'd1 : year_s1;
		prod_y  = DIV100_PROD_W'(year_s1) * DIV100_PROD_W'(DIV100_MUL);
		prod_w  = DIV100_PROD_W'(wk_year) * DIV100_PROD_W'(DIV100_MUL);
		prod_w4 = DIV100_PROD_W'(wk_year[YEAR_W-1:2]) * DIV100_PROD_W'(DIV100_MUL);
		data_nxt.year      = year_s1;
		data_nxt.month     = month_s1;
		data_nxt.day       = day_s1;
		data_nxt.wk_year   = wk_year;
		data_nxt.year_q100 = prod_y[DIV100_SHIFT +: Q100_W];
		data_nxt.wk_q100   = prod_w[DIV100_SHIFT +: Q100_W];
		data_nxt.wk_q400   = prod_w4[DIV100_SHIFT +: Q400_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			data_s2 <= data_nxt;
		end
	end

	cdp_calc u_calc (
		.s2  (data_s2),
		.res (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (rdy_out) begin
			res_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && vld_s2) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid     = res_vld_q;
	assign date_valid    = res_q.date_valid;
	assign weekday       = res_q.weekday;
	assign end_of_week   = res_q.end_of_week;
	assign weekend       = res_q.weekend;
	assign leap_year     = res_q.leap_year;
	assign month_length  = res_q.month_length;
	assign left_in_week  = res_q.left_in_week;
	assign left_in_month = res_q.left_in_month;
	assign left_in_year  = res_q.left_in_year;
	assign next_day      = res_q.next_day;
	assign next_month    = res_q.next_month;
	assign next_year     = res_q.next_year;

endmodule

// ===== rtl/core/cdp_checker.sv =====
module cdp_checker import cdp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               date_valid,
	input logic [WD_W-1:0]    weekday,
	input logic               end_of_week,
	input logic               weekend,
	input logic               leap_year,
	input logic [DAY_W-1:0]   month_length,
	input logic [WD_W-1:0]    left_in_week,
	input logic [DAY_W-1:0]   left_in_month,
	input logic [YDAY_W-1:0]  left_in_year,
	input logic [DAY_W-1:0]   next_day,
	input logic [MONTH_W-1:0] next_month,
	input logic [YEAR_W-1:0]  next_year
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(next_year) && $stable(weekday)
			&& $stable(left_in_year) && $stable(date_valid))
		else $error("stalled result changed");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !date_valid |-> weekday == '0 && !end_of_week && !weekend && !leap_year
			&& month_length == '0 && left_in_week == '0 && left_in_month == '0
			&& left_in_year == '0 && next_day == '0 && next_month == '0 && next_year == '0)
		else $error("invalid date with nonzero fields");

	a_week_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && date_valid |-> left_in_week == WD_SATURDAY - weekday
			&& end_of_week == (weekday == WD_SATURDAY)
			&& weekend == (weekday == WD_FRIDAY || weekday == WD_SATURDAY))
		else $error("week fields disagree");

	a_next_day: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && date_valid |-> (left_in_month == '0) ? (next_day == 5'd1)
			: (next_day == month_length - left_in_month + 5'd1))
		else $error("next day disagrees with days left in month");

	a_year_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && date_valid && left_in_year == 9'd1 |-> next_month == MONTH_JAN
			&& next_day == 5'd1 && left_in_month == '0)
		else $error("year end without rollover");

endmodule

bind calendar_date_properties cdp_checker u_cdp_checker (.*);

// ===== tb/calendar_date_checker.sv =====
module calendar_date_checker import cdp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [YEAR_W-1:0]  year,
	input  logic [MONTH_W-1:0] month,
	input  logic [DAY_W-1:0]   day,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               date_valid,
	input  logic [WD_W-1:0]    weekday,
	input  logic               end_of_week,
	input  logic               weekend,
	input  logic               leap_year,
	input  logic [DAY_W-1:0]   month_length,
	input  logic [WD_W-1:0]    left_in_week,
	input  logic [DAY_W-1:0]   left_in_month,
	input  logic [YDAY_W-1:0]  left_in_year,
	input  logic [DAY_W-1:0]   next_day,
	input  logic [MONTH_W-1:0] next_month,
	input  logic [YEAR_W-1:0]  next_year,
	output int                 mismatches,
	output int                 pending,
	output int                 checked,
	output int                 valid_dates
);
	timeunit 1ns;
	timeprecision 1ps;

	int mdays [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	cdp_res_t expected_props [$];
	cdp_res_t want;
	cdp_res_t pred;

	function automatic cdp_res_t date_props(input logic [YEAR_W-1:0] y_in,
			input logic [MONTH_W-1:0] m_in, input logic [DAY_W-1:0] d_in);
		cdp_res_t r;
		int y, m, d, mlen, wd, doy, ylen, shift, yy, mm, i;
		bit leap;
		r = '0;
		y = int'(y_in);
		m = int'(m_in);
		d = int'(d_in);
		if (y < 1 || y > int'(YEAR_MAX) || m < int'(MONTH_JAN) || m > int'(MONTH_DEC)) begin
			return r;
		end
		leap = (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
		mlen = (m == int'(MONTH_FEB)) ? (leap ? 29 : 28) : mdays[m];
		if (d < 1 || d > mlen) begin
			return r;
		end
		// count the year from March so that the leap day falls last
		shift = (m <= int'(MONTH_FEB)) ? 1 : 0;
		yy = y - shift;
		mm = m + 12 * shift - 2;
		wd = (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
		doy = d;
		for (i = 1; i < m; i++) begin
			doy += mdays[i];
		end
		if (leap && m > int'(MONTH_FEB)) begin
			doy++;
		end
		ylen = leap ? 366 : 365;
		r.date_valid    = 1'b1;
		r.weekday       = WD_W'(wd);
		r.end_of_week   = (wd == int'(WD_SATURDAY));
		r.weekend       = (wd == int'(WD_FRIDAY)) || (wd == int'(WD_SATURDAY));
		r.leap_year     = leap;
		r.month_length  = DAY_W'(mlen);
		r.left_in_week  = WD_W'(6 - wd);
		r.left_in_month = DAY_W'(mlen - d);
		r.left_in_year  = YDAY_W'(ylen - doy + 1);
		if (d == mlen) begin
			r.next_day = DAY_W'(1);
			if (m == int'(MONTH_DEC)) begin
				r.next_month = MONTH_JAN;
				r.next_year  = YEAR_W'(y + 1);
			end else begin
				r.next_month = MONTH_W'(m + 1);
				r.next_year  = YEAR_W'(y);
			end
		end else begin
			r.next_day   = DAY_W'(d + 1);
			r.next_month = MONTH_W'(m);
			r.next_year  = YEAR_W'(y);
		end
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned expv,
			input int unsigned gotv);
		if (expv != gotv) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("result %0d: %s expected %0d, got %0d", checked, name, expv, gotv);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_props.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result transfer with no date outstanding");
					end
				end else begin
					want = expected_props.pop_front();
					check_field("date_valid", 32'(want.date_valid), 32'(date_valid));
					check_field("weekday", 32'(want.weekday), 32'(weekday));
					check_field("end_of_week", 32'(want.end_of_week), 32'(end_of_week));
					check_field("weekend", 32'(want.weekend), 32'(weekend));
					check_field("leap_year", 32'(want.leap_year), 32'(leap_year));
					check_field("month_length", 32'(want.month_length), 32'(month_length));
					check_field("left_in_week", 32'(want.left_in_week), 32'(left_in_week));
					check_field("left_in_month", 32'(want.left_in_month),
						32'(left_in_month));
					check_field("left_in_year", 32'(want.left_in_year), 32'(left_in_year));
					check_field("next_day", 32'(want.next_day), 32'(next_day));
					check_field("next_month", 32'(want.next_month), 32'(next_month));
					check_field("next_year", 32'(want.next_year), 32'(next_year));
					checked++;
				end
			end
			if (in_valid && !in_stall) begin
				pred = date_props(year, month, day);
				expected_props.push_back(pred);
				if (pred.date_valid) begin
					valid_dates++;
				end
			end
			pending = expected_props.size();
		end
	end

endmodule

// ===== tb/calendar_date_properties_tb.sv =====
module calendar_date_properties_tb import cdp_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_DATES = 1400;
	localparam int LONG_HOLD    = 300;
	localparam int STUCK_LIMIT  = 4000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [YEAR_W-1:0]  year;
	logic [MONTH_W-1:0] month;
	logic [DAY_W-1:0]   day;
	logic               out_valid;
	logic               out_stall;
	logic               date_valid;
	logic [WD_W-1:0]    weekday;
	logic               end_of_week;
	logic               weekend;
	logic               leap_year;
	logic [DAY_W-1:0]   month_length;
	logic [WD_W-1:0]    left_in_week;
	logic [DAY_W-1:0]   left_in_month;
	logic [YDAY_W-1:0]  left_in_year;
	logic [DAY_W-1:0]   next_day;
	logic [MONTH_W-1:0] next_month;
	logic [YEAR_W-1:0]  next_year;

	int  mismatches;
	int  pending;
	int  checked;
	int  valid_dates;
	int  sent;
	int  stuck;
	int  hold_req;
	int  hold_done;
	int  stall_left;
	bit  quiet_tx;
	bit  quiet_rx;

	calendar_date_properties uut (.*);

	calendar_date_checker chk (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 2);
		end else if (r < 95) begin
			return $urandom_range(3, 8);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic drive_date(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
			input logic [DAY_W-1:0] d);
		int g;
		if (!quiet_tx && $urandom_range(0, 2) == 0) begin
			g = gap_len();
			repeat (g) begin
				@(negedge clk);
				in_valid = 1'b0;
			end
		end
		@(negedge clk);
		year     = y;
		month    = m;
		day      = d;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic drive_random_date();
		int r;
		int kind;
		logic [YEAR_W-1:0]  y;
		logic [MONTH_W-1:0] m;
		logic [DAY_W-1:0]   d;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			kind = $urandom_range(0, 3);
			if (kind < 2) begin
				y = YEAR_W'($urandom_range(1, 9999));
			end else if (kind == 2) begin
				y = YEAR_W'($urandom_range(0, 99) * 100 + $urandom_range(0, 4));
			end else if ($urandom_range(0, 1)) begin
				y = YEAR_W'($urandom_range(9990, 9999));
			end else begin
				y = YEAR_W'($urandom_range(1, 10));
			end
			m = MONTH_W'($urandom_range(1, 12));
			d = DAY_W'(($urandom_range(0, 3) == 0) ? $urandom_range(28, 31)
				: $urandom_range(1, 28));
		end else if (r < 85) begin
			y = YEAR_W'($urandom_range(1, 9999));
			m = MONTH_W'($urandom_range(0, 15));
			d = DAY_W'($urandom_range(0, 31));
		end else begin
			y = YEAR_W'($urandom_range(0, 16383));
			m = MONTH_W'($urandom_range(0, 15));
			d = DAY_W'($urandom_range(0, 31));
		end
		drive_date(y, m, d);
	endtask

	// receiver: random stalls, or one long hold on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_done) begin
				out_stall = 1'b1;
				repeat (LONG_HOLD - 1) @(negedge clk);
				hold_done++;
				stall_left = 0;
			end else if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				out_stall = 1'b0;
				if (!quiet_rx && $urandom_range(0, 3) == 0) begin
					stall_left = gap_len();
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				stuck = 0;
			end else begin
				stuck++;
			end
			if (stuck >= STUCK_LIMIT) begin
				$display("no transfer for %0d cycles, %0d results outstanding", stuck, pending);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		year     = '0;
		month    = '0;
		day      = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		drive_date(14'd1, 4'd1, 5'd1);
		drive_date(14'd9999, 4'd12, 5'd31);
		drive_date(14'd9999, 4'd12, 5'd30);
		drive_date(14'd2000, 4'd2, 5'd29);
		drive_date(14'd1900, 4'd2, 5'd29);
		drive_date(14'd1900, 4'd2, 5'd28);
		drive_date(14'd2024, 4'd2, 5'd29);
		drive_date(14'd2023, 4'd2, 5'd29);
		drive_date(14'd2024, 4'd2, 5'd28);
		drive_date(14'd2024, 4'd3, 5'd1);
		drive_date(14'd2023, 4'd12, 5'd31);
		drive_date(14'd2024, 4'd12, 5'd31);
		drive_date(14'd2023, 4'd4, 5'd30);
		drive_date(14'd2023, 4'd4, 5'd31);
		drive_date(14'd2023, 4'd0, 5'd10);
		drive_date(14'd2023, 4'd13, 5'd10);
		drive_date(14'd2023, 4'd15, 5'd31);
		drive_date(14'd2023, 4'd6, 5'd0);
		drive_date(14'd0, 4'd6, 5'd15);
		drive_date(14'd10000, 4'd1, 5'd1);
		drive_date(14'd16383, 4'd15, 5'd31);
		drive_date(14'd2024, 4'd6, 5'd7);
		drive_date(14'd2024, 4'd6, 5'd8);
		drive_date(14'd2024, 4'd6, 5'd9);

		for (int i = 0; i < RANDOM_DATES; i++) begin
			if (i == 400) begin
				hold_req++;
				quiet_tx = 1'b1;
			end
			if (i == 460) begin
				quiet_tx = 1'b0;
			end
			if (i == 800) begin
				@(negedge clk);
				in_valid = 1'b0;
				wait (pending == 0);
			end
			if (i == 1000) begin
				quiet_tx = 1'b1;
				quiet_rx = 1'b1;
			end
			if (i == 1150) begin
				quiet_tx = 1'b0;
				quiet_rx = 1'b0;
			end
			drive_random_date();
		end

		@(negedge clk);
		in_valid = 1'b0;
		wait (pending == 0);
		repeat (8) @(posedge clk);

		$display("%0d dates sent, %0d of them real calendar dates; %0d results checked",
			sent, valid_dates, checked);
		$display("covered leap and century years, month and year rollover, bad fields, stalls");
		if (mismatches == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/cdp_pkg.sv
rtl/core/cdp_calc.sv
rtl/core/calendar_date_properties.sv
rtl/core/cdp_checker.sv
tb/calendar_date_checker.sv
tb/calendar_date_properties_tb.sv
